FILE: sv/dba_pkg.sv
// ----------------------------------------------------------------------------
// dba_pkg
// Shared types, command codes and digit helpers for the decimal bignum ALU.
// ----------------------------------------------------------------------------
package dba_pkg;

  localparam int DIGITS_DEFAULT = 32;

  typedef enum logic [2:0] {
    CMD_LOAD     = 3'd0,
    CMD_CLEAR    = 3'd1,
    CMD_ADD      = 3'd2,
    CMD_SUBTRACT = 3'd3,
    CMD_MULTIPLY = 3'd4,
    CMD_DIVIDE   = 3'd5,
    CMD_COMPARE  = 3'd6,
    CMD_UNUSED   = 3'd7
  } cmd_t;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_ADDSUB   = 10'b0000000010,
    S_CMPR     = 10'b0000000100,
    S_MUL      = 10'b0000001000,
    S_DIVSHIFT = 10'b0000010000,
    S_DIVTRIAL = 10'b0000100000,
    S_LEN      = 10'b0001000000,
    S_EMIT     = 10'b0010000000,
    S_EMITCMP  = 10'b0100000000,
    S_SPARE    = 10'b1000000000
  } state_t;

  // Quotient by ten for values below one hundred: multiply by 103, drop 10 bits.
  function automatic logic [3:0] div10(input logic [6:0] s);
    logic [13:0] prod;
    prod = 14'(s) * 14'd103;
    return prod[13:10];
  endfunction

endpackage

FILE: sv/decimal_bignum_alu.sv
// ----------------------------------------------------------------------------
// decimal_bignum_alu
// Fixed-length decimal unit with digit-serial add, subtract, multiply,
// divide and compare over two operand stores.
// ----------------------------------------------------------------------------
// Loads and clears produce no output words. Every other command runs one
// decimal digit per cycle through rotating digit shift lines: add, subtract
// and compare make one pass over the DIGITS digits, multiply makes DIGITS
// passes over the 2*DIGITS product digits (shift-and-add of one multiplier
// digit per pass), and divide makes up to nine trial subtractions over the
// DIGITS+1 remainder digits for each quotient digit. Arithmetic commands then
// find the result length before the result words go out, one digit per
// accepted word, least significant first. A new command is taken only once
// the previous one has delivered its last word.
module decimal_bignum_alu #(
  parameter int DIGITS = dba_pkg::DIGITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command[2:0], operand_select[3], digit_index[8:4], digit_value[12:9]
  input  logic [15:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // result_digit[3:0], digit_position[8:4], overflow[9], inexact[10],
  // equal[11], result_length[17:12]
  output logic [23:0] m_tdata,
  output logic        m_tlast
);

  localparam int EC = (DIGITS < 32) ? DIGITS : 32;
  localparam int CW = $clog2(2 * DIGITS + 1);
  localparam int DW = $clog2(DIGITS + 1);

  dba_pkg::state_t state;

  logic [3:0] first_operand  [DIGITS];
  logic [3:0] second_operand [DIGITS];
  logic [3:0] result_store   [DIGITS];
  logic [3:0] prod           [2*DIGITS];
  logic [3:0] rem            [DIGITS+1];
  logic [3:0] trial          [DIGITS+1];

  logic          carry_digit;
  logic          is_sub;
  logic [CW-1:0] cnt;
  logic [DW-1:0] dcnt;
  logic [3:0]    prev;
  logic [3:0]    mcarry;
  logic [3:0]    quo;
  logic          or_rem;
  logic          or_trial;
  logic          bnz;
  logic          remnz;
  logic          ovf;
  logic          inx;
  logic          eq;
  logic [6:0]    len;

  // Input word fields.
  dba_pkg::cmd_t in_cmd;
  logic          in_sel;
  logic [4:0]    in_idx;
  logic [3:0]    in_val;
  logic [3:0]    in_val_clamped;

  assign in_cmd = dba_pkg::cmd_t'(s_tdata[2:0]);
  assign in_sel = s_tdata[3];
  assign in_idx = s_tdata[8:4];
  assign in_val = s_tdata[12:9];
  assign in_val_clamped = (in_val > 4'd9) ? 4'd9 : in_val;

  // Add and subtract digit.
  logic [4:0] as_sum;
  logic [4:0] as_sub;
  logic [3:0] as_digit;
  logic       as_carry;

  always_comb begin
    as_sum = 5'(first_operand[0]) + 5'(second_operand[0]) + 5'(carry_digit);
    as_sub = 5'(second_operand[0]) + 5'(carry_digit);
    if (is_sub) begin
      if (5'(first_operand[0]) < as_sub) begin
        as_digit = 4'(5'(first_operand[0]) + 5'd10 - as_sub);
        as_carry = 1'b1;
      end else begin
        as_digit = 4'(5'(first_operand[0]) - as_sub);
        as_carry = 1'b0;
      end
    end else begin
      if (as_sum >= 5'd10) begin
        as_digit = 4'(as_sum - 5'd10);
        as_carry = 1'b1;
      end else begin
        as_digit = as_sum[3:0];
        as_carry = 1'b0;
      end
    end
  end

  // Multiply digit: previous product digit plus a times the multiplier digit.
  logic       mul_in_range;
  logic [3:0] mul_a;
  logic [7:0] mul_ab;
  logic [6:0] mul_sum;
  logic [3:0] mul_q;
  logic [3:0] mul_digit;

  always_comb begin
    mul_in_range = (cnt < CW'(DIGITS));
    mul_a   = mul_in_range ? first_operand[0] : 4'd0;
    mul_ab  = 8'(mul_a) * 8'(second_operand[DIGITS-1]);
    mul_sum = 7'(prev) + 7'(mul_ab) + 7'(mcarry);
    mul_q   = dba_pkg::div10(mul_sum);
    mul_digit = 4'(mul_sum - 7'(mul_q) * 7'd10);
  end

  // Divide trial subtraction digit.
  logic [3:0] dv_b;
  logic [4:0] dv_t;
  logic [3:0] dv_digit;
  logic       dv_borrow;

  always_comb begin
    dv_b = mul_in_range ? second_operand[0] : 4'd0;
    dv_t = 5'(dv_b) + 5'(carry_digit);
    if (5'(rem[0]) < dv_t) begin
      dv_digit  = 4'(5'(rem[0]) + 5'd10 - dv_t);
      dv_borrow = 1'b1;
    end else begin
      dv_digit  = 4'(5'(rem[0]) - dv_t);
      dv_borrow = 1'b0;
    end
  end

  logic pass_end;
  logic skip_pass;
  logic commit;
  logic digit_done;

  assign pass_end   = (cnt == CW'(DIGITS));
  assign skip_pass  = (cnt == '0) && (quo == 4'd9);
  assign commit     = pass_end && !dv_borrow;
  assign digit_done = skip_pass || (pass_end && dv_borrow);

  assign s_tready = (state == dba_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dba_pkg::S_IDLE;
      carry_digit <= 1'b0;
      for (int k = 0; k < DIGITS; k++) begin
        first_operand[k]  <= 4'd0;
        second_operand[k] <= 4'd0;
      end
    end else begin
      unique case (state)
        dba_pkg::S_IDLE: begin
          if (s_tvalid) begin
            cnt <= '0;
            unique case (in_cmd)
              dba_pkg::CMD_LOAD: begin
                for (int k = 0; k < DIGITS; k++) begin
                  if ({27'd0, in_idx} == k) begin
                    if (in_sel) second_operand[k] <= in_val_clamped;
                    else first_operand[k] <= in_val_clamped;
                  end
                end
              end
              dba_pkg::CMD_CLEAR: begin
                carry_digit <= 1'b0;
                for (int k = 0; k < DIGITS; k++) begin
                  first_operand[k]  <= 4'd0;
                  second_operand[k] <= 4'd0;
                end
              end
              dba_pkg::CMD_ADD, dba_pkg::CMD_SUBTRACT: begin
                carry_digit <= 1'b0;
                is_sub      <= (in_cmd == dba_pkg::CMD_SUBTRACT);
                inx         <= 1'b0;
                state       <= dba_pkg::S_ADDSUB;
              end
              dba_pkg::CMD_MULTIPLY: begin
                for (int k = 0; k < 2 * DIGITS; k++) prod[k] <= 4'd0;
                dcnt   <= '0;
                prev   <= 4'd0;
                mcarry <= 4'd0;
                ovf    <= 1'b0;
                inx    <= 1'b0;
                state  <= dba_pkg::S_MUL;
              end
              dba_pkg::CMD_DIVIDE: begin
                for (int k = 0; k <= DIGITS; k++) rem[k] <= 4'd0;
                dcnt  <= '0;
                bnz   <= 1'b0;
                remnz <= 1'b0;
                ovf   <= 1'b0;
                state <= dba_pkg::S_DIVSHIFT;
              end
              dba_pkg::CMD_COMPARE: begin
                eq    <= 1'b1;
                state <= dba_pkg::S_CMPR;
              end
              default: begin
              end
            endcase
          end
        end

        dba_pkg::S_ADDSUB: begin
          for (int k = 0; k < DIGITS - 1; k++) begin
            first_operand[k]  <= first_operand[k+1];
            second_operand[k] <= second_operand[k+1];
            result_store[k]   <= result_store[k+1];
          end
          first_operand[DIGITS-1]  <= first_operand[0];
          second_operand[DIGITS-1] <= second_operand[0];
          result_store[DIGITS-1]   <= as_digit;
          carry_digit <= as_carry;
          cnt <= cnt + 1'b1;
          if (cnt == CW'(DIGITS - 1)) begin
            ovf   <= as_carry;
            cnt   <= '0;
            len   <= 7'd0;
            state <= dba_pkg::S_LEN;
          end
        end

        dba_pkg::S_CMPR: begin
          for (int k = 0; k < DIGITS - 1; k++) begin
            first_operand[k]  <= first_operand[k+1];
            second_operand[k] <= second_operand[k+1];
          end
          first_operand[DIGITS-1]  <= first_operand[0];
          second_operand[DIGITS-1] <= second_operand[0];
          if (first_operand[0] != second_operand[0]) eq <= 1'b0;
          cnt <= cnt + 1'b1;
          if (cnt == CW'(DIGITS - 1)) state <= dba_pkg::S_EMITCMP;
        end

        dba_pkg::S_MUL: begin
          // One pass adds a times the multiplier digit into ten times the
          // running product, the multiplier taken most significant first.
          for (int k = 0; k < 2 * DIGITS - 1; k++) prod[k] <= prod[k+1];
          prod[2*DIGITS-1] <= mul_digit;
          prev   <= prod[0];
          mcarry <= mul_q;
          if (mul_in_range) begin
            for (int k = 0; k < DIGITS - 1; k++) first_operand[k] <= first_operand[k+1];
            first_operand[DIGITS-1] <= first_operand[0];
          end
          if (dcnt == DW'(DIGITS - 1) && !mul_in_range && mul_digit != 4'd0) ovf <= 1'b1;
          cnt <= cnt + 1'b1;
          if (cnt == CW'(2 * DIGITS - 1)) begin
            cnt    <= '0;
            prev   <= 4'd0;
            mcarry <= 4'd0;
            for (int k = 1; k < DIGITS; k++) second_operand[k] <= second_operand[k-1];
            second_operand[0] <= second_operand[DIGITS-1];
            dcnt <= dcnt + 1'b1;
            if (dcnt == DW'(DIGITS - 1)) begin
              for (int k = 0; k < DIGITS; k++) result_store[k] <= prod[k+1];
              len   <= 7'd0;
              state <= dba_pkg::S_LEN;
            end
          end
        end

        dba_pkg::S_DIVSHIFT: begin
          // Bring down the next dividend digit, most significant first.
          for (int k = 1; k <= DIGITS; k++) rem[k] <= rem[k-1];
          rem[0] <= first_operand[DIGITS-1];
          for (int k = 1; k < DIGITS; k++) first_operand[k] <= first_operand[k-1];
          first_operand[0] <= first_operand[DIGITS-1];
          quo         <= 4'd0;
          cnt         <= '0;
          carry_digit <= 1'b0;
          or_rem      <= 1'b0;
          or_trial    <= 1'b0;
          state       <= dba_pkg::S_DIVTRIAL;
        end

        dba_pkg::S_DIVTRIAL: begin
          if (!skip_pass) begin
            for (int k = 0; k < DIGITS; k++) begin
              rem[k]   <= rem[k+1];
              trial[k] <= trial[k+1];
            end
            rem[DIGITS]   <= rem[0];
            trial[DIGITS] <= dv_digit;
            if (mul_in_range) begin
              for (int k = 0; k < DIGITS - 1; k++) second_operand[k] <= second_operand[k+1];
              second_operand[DIGITS-1] <= second_operand[0];
            end
            carry_digit <= dv_borrow;
            if (rem[0] != 4'd0) or_rem <= 1'b1;
            if (dv_digit != 4'd0) or_trial <= 1'b1;
            if (dv_b != 4'd0) bnz <= 1'b1;
            cnt <= cnt + 1'b1;
          end
          if (commit) begin
            // The remainder was at least the divisor: keep the difference.
            for (int k = 0; k < DIGITS; k++) rem[k] <= trial[k+1];
            rem[DIGITS] <= dv_digit;
            remnz       <= or_trial || (dv_digit != 4'd0);
            quo         <= quo + 4'd1;
            cnt         <= '0;
            carry_digit <= 1'b0;
            or_rem      <= 1'b0;
            or_trial    <= 1'b0;
          end
          if (pass_end && dv_borrow) remnz <= or_rem || (rem[0] != 4'd0);
          if (digit_done) begin
            for (int k = 1; k < DIGITS; k++) result_store[k] <= result_store[k-1];
            result_store[0] <= quo;
            dcnt  <= dcnt + 1'b1;
            state <= dba_pkg::S_DIVSHIFT;
            if (dcnt == DW'(DIGITS - 1)) begin
              cnt   <= '0;
              len   <= 7'd0;
              state <= dba_pkg::S_LEN;
              inx   <= !bnz || (skip_pass ? remnz : (or_rem || (rem[0] != 4'd0)));
              if (!bnz) begin
                for (int k = 0; k < DIGITS; k++) result_store[k] <= 4'd0;
              end
            end
          end
        end

        dba_pkg::S_LEN: begin
          for (int k = 0; k < DIGITS - 1; k++) result_store[k] <= result_store[k+1];
          result_store[DIGITS-1] <= result_store[0];
          if (result_store[0] != 4'd0) len <= 7'(cnt) + 7'd1;
          cnt <= cnt + 1'b1;
          if (cnt == CW'(DIGITS - 1)) begin
            cnt   <= '0;
            state <= dba_pkg::S_EMIT;
          end
        end

        dba_pkg::S_EMIT: begin
          if (m_tready) begin
            for (int k = 0; k < DIGITS - 1; k++) result_store[k] <= result_store[k+1];
            result_store[DIGITS-1] <= result_store[0];
            cnt <= cnt + 1'b1;
            if (cnt == CW'(EC - 1)) state <= dba_pkg::S_IDLE;
          end
        end

        dba_pkg::S_EMITCMP: begin
          if (m_tready) state <= dba_pkg::S_IDLE;
        end

        default: state <= dba_pkg::S_IDLE;
      endcase
    end
  end

  // The length can only pass 63 when the stores are wider than 63 digits.
  logic [5:0] len_sat;
  assign len_sat = (len > 7'd63) ? 6'd63 : len[5:0];

  always_comb begin
    m_tvalid = 1'b0;
    m_tlast  = 1'b0;
    m_tdata  = '0;
    if (state == dba_pkg::S_EMIT) begin
      m_tvalid       = 1'b1;
      m_tlast        = (cnt == CW'(EC - 1));
      m_tdata[3:0]   = result_store[0];
      m_tdata[8:4]   = 5'(cnt);
      m_tdata[9]     = ovf;
      m_tdata[10]    = inx;
      m_tdata[17:12] = len_sat;
    end else if (state == dba_pkg::S_EMITCMP) begin
      m_tvalid    = 1'b1;
      m_tlast     = 1'b1;
      m_tdata[11] = eq;
    end
  end

endmodule
